// ----- design/lfsa_pkg.sv -----
// Shared types, codes and sizes of the lowest free slot allocator.
package lfsa_pkg;

   // array shape and tag width
   localparam int MAX_LEVELS          = 8;
   localparam int MAX_SLOTS_PER_LEVEL = 32;
   localparam int TAG_BITS            = 32;
   localparam int SLOT_TOTAL          = MAX_LEVELS * MAX_SLOTS_PER_LEVEL;
   localparam int IDX_W               = $clog2(SLOT_TOTAL);

   // result and register field widths
   localparam int STATUS_W   = 2;
   localparam int LVL_W      = 3;
   localparam int POS_W      = 5;
   localparam int LVL_CFG_W  = 4;
   localparam int SPL_CFG_W  = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FREE   = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_DUPLICATE = 2'd3
   } status_type;

   typedef enum logic {
      REG_LEVEL_COUNT     = 1'b0,
      REG_SLOTS_PER_LEVEL = 1'b1
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_REPLY = 2'd2
   } state_type;

   // area in use, already saturated
   typedef struct packed {
      logic [LVL_CFG_W-1:0] lv_use;
      logic [SPL_CFG_W-1:0] sp_use;
   } cfg_type;

   // request token that walks the cell chain
   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [TAG_BITS-1:0] tag;
      logic                free_hit;
      logic [IDX_W-1:0]    free_idx;
      logic                tag_hit;
      logic [IDX_W-1:0]    tag_idx;
   } scan_type;

   // update of one slot once the scan is done
   typedef struct packed {
      logic                en;
      logic                set;
      logic [IDX_W-1:0]    idx;
      logic [TAG_BITS-1:0] tag;
   } commit_type;

endpackage

// ----- design/lfsa_req_if.sv -----
// Request channel: valid/ready handshake with request type and owner tag.
interface lfsa_req_if import lfsa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [TAG_BITS-1:0] owner_tag;

   modport source (output valid, output req_type, output owner_tag, input ready);
   modport sink   (input valid, input req_type, input owner_tag, output ready);
endinterface

// ----- design/lfsa_rsp_if.sv -----
// Response channel: valid/ready handshake with status and slot location.
interface lfsa_rsp_if import lfsa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [LVL_W-1:0]    level_index;
   logic [POS_W-1:0]    position_index;

   modport source (output valid, output status, output level_index, output position_index,
                   input ready);
   modport sink   (input valid, input status, input level_index, input position_index,
                   output ready);
endinterface

// ----- design/lfsa_cell.sv -----
// One slot of the allocator: occupied mark, holder tag and one stage of the scan chain.
module lfsa_cell import lfsa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic [IDX_W-1:0] cell_level,
   input  logic [IDX_W-1:0] cell_pos,
   input  cfg_type          cfg,
   input  scan_type         scan_in,
   input  commit_type       commit,
   output scan_type         scan_out
);

   logic                occupied_ff, occupied_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic                tok_valid_ff;
   scan_type            tok_ff, tok_in;
   logic                in_use;
   logic                commit_hit;

   assign in_use = (cell_level < IDX_W'(cfg.lv_use)) && (cell_pos < IDX_W'(cfg.sp_use));
   assign commit_hit = commit.en && (commit.idx == cell_idx);

   // take or release this slot when the controller picks it
   always_comb begin
      occupied_in = occupied_ff;
      tag_in      = tag_ff;
      if (commit_hit) begin
         occupied_in = commit.set;
         if (commit.set) begin
            tag_in = commit.tag;
         end
      end
   end

   // mark the first free slot in use and the first holder of the tag
   always_comb begin
      tok_in = scan_in;
      if (!scan_in.free_hit && in_use && !occupied_ff) begin
         tok_in.free_hit = 1'b1;
         tok_in.free_idx = cell_idx;
      end
      if (!scan_in.tag_hit && occupied_ff && (tag_ff == scan_in.tag)) begin
         tok_in.tag_hit = 1'b1;
         tok_in.tag_idx = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff  <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         occupied_ff  <= occupied_in;
         tok_valid_ff <= scan_in.valid;
      end
   end

   // hand the token on; stored tag has no reset
   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      tok_ff <= tok_in;
   end

   always_comb begin
      scan_out       = tok_ff;
      scan_out.valid = tok_valid_ff;
   end

endmodule

// ----- design/lfsa_csr.sv -----
// Configuration registers behind the APB-style port, with saturation to the array size.
module lfsa_csr import lfsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [LVL_CFG_W-1:0] level_count_ff, level_count_in;
   logic [SPL_CFG_W-1:0] slots_per_level_ff, slots_per_level_in;
   logic                 wr_en;
   reg_type              reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = reg_type'(csr_paddr[2]);

   // write the addressed register
   always_comb begin
      level_count_in     = level_count_ff;
      slots_per_level_in = slots_per_level_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_LEVEL_COUNT:     level_count_in     = csr_pwdata[LVL_CFG_W-1:0];
            REG_SLOTS_PER_LEVEL: slots_per_level_in = csr_pwdata[SPL_CFG_W-1:0];
            default: begin
               level_count_in     = level_count_ff;
               slots_per_level_in = slots_per_level_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff     <= LVL_CFG_W'(MAX_LEVELS);
         slots_per_level_ff <= SPL_CFG_W'(MAX_SLOTS_PER_LEVEL);
      end else begin
         level_count_ff     <= level_count_in;
         slots_per_level_ff <= slots_per_level_in;
      end
   end

   // read back the raw register value
   always_comb begin
      case (reg_sel)
         REG_LEVEL_COUNT:     csr_prdata = CSR_DATA_W'(level_count_ff);
         REG_SLOTS_PER_LEVEL: csr_prdata = CSR_DATA_W'(slots_per_level_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // clamp the area in use to the array size
   assign cfg.lv_use = (level_count_ff > LVL_CFG_W'(MAX_LEVELS)) ?
                       LVL_CFG_W'(MAX_LEVELS) : level_count_ff;
   assign cfg.sp_use = (slots_per_level_ff > SPL_CFG_W'(MAX_SLOTS_PER_LEVEL)) ?
                       SPL_CFG_W'(MAX_SLOTS_PER_LEVEL) : slots_per_level_ff;

endmodule

// ----- design/lowest_free_slot_allocator_top.sv -----
// Top level of the lowest free slot allocator: controller, registers and cell chain.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        req_type, owner_tag
//   rsp_chan  out        valid/ready        status, level_index, position_index
//   csr_*     in/out     APB-style, 2 regs  level_count @0x0, slots_per_level @0x4
//
// An accepted request walks the chain of 256 slot cells, one cell per cycle; the
// slot update and response load happen together, as the token leaves the chain.
// One request is in flight at a time: the next one is accepted only after the
// response is taken. Reset clears every occupied mark at once, no clearing pass.
// A stalled response holds its register and blocks new requests.
module lowest_free_slot_allocator_top import lfsa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lfsa_req_if.sink              req_chan,
   lfsa_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type              cfg;
   scan_type             head;
   scan_type             chain [SLOT_TOTAL+1];
   logic [SLOT_TOTAL-1:0] tok_live;
   commit_type           commit;
   state_type            state_ff, state_in;
   status_type           rsp_status_ff, rsp_status_in, res_status;
   logic [IDX_W-1:0]     rsp_slot_ff, rsp_slot_in, res_slot;
   logic                 req_accept;
   logic                 res_set;
   scan_type             last;

   lfsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // launch a fresh token into the head of the chain
   always_comb begin
      head          = '0;
      head.valid    = req_accept;
      head.op       = op_type'(req_chan.req_type);
      head.tag      = req_chan.owner_tag;
   end

   assign chain[0] = head;

   for (genvar i = 0; i < SLOT_TOTAL; i++) begin : g_cell
      lfsa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_W'(i)),
         .cell_level (IDX_W'(i / MAX_SLOTS_PER_LEVEL)),
         .cell_pos   (IDX_W'(i % MAX_SLOTS_PER_LEVEL)),
         .cfg        (cfg),
         .scan_in    (chain[i]),
         .commit     (commit),
         .scan_out   (chain[i+1])
      );
      assign tok_live[i] = chain[i+1].valid;
   end

   assign last = chain[SLOT_TOTAL];

   // decide the outcome from the token leaving the chain
   always_comb begin
      res_status = STATUS_OK;
      res_slot   = '0;
      res_set    = 1'b0;
      if (last.op == OP_ALLOC) begin
         if (!last.free_hit) begin
            res_status = STATUS_NO_FREE;
         end else if (last.tag_hit) begin
            res_status = STATUS_DUPLICATE;
         end else begin
            res_slot = last.free_idx;
            res_set  = 1'b1;
         end
      end else begin
         if (!last.tag_hit) begin
            res_status = STATUS_NOT_FOUND;
         end else begin
            res_slot = last.tag_idx;
         end
      end
   end

   // sequence the scan, the slot update and the response
   always_comb begin
      state_in      = state_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      commit        = '0;
      commit.set    = res_set;
      commit.idx    = res_slot;
      commit.tag    = last.tag;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last.valid) begin
               commit.en     = (res_status == STATUS_OK);
               rsp_status_in = res_status;
               rsp_slot_in   = res_slot;
               state_in      = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the response payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_chan.valid          = (state_ff == ST_REPLY);
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.level_index    = LVL_W'(rsp_slot_ff / MAX_SLOTS_PER_LEVEL);
   assign rsp_chan.position_index = POS_W'(rsp_slot_ff % MAX_SLOTS_PER_LEVEL);

`ifndef SYNTH
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_live) <= 1)
      else $error("more than one request token in the cell chain");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (tok_live == '0))
      else $error("token in the chain while idle");

   a_launch: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN) && chain[1].valid)
      else $error("accepted request did not enter the chain");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status != STATUS_OK) |->
         (rsp_chan.level_index == '0) && (rsp_chan.position_index == '0))
      else $error("error response carries a slot location");
`endif

endmodule

// ----- tb/testbench.sv -----
// Testbench for the lowest free slot allocator: directed and random requests checked against a ledger.
`timescale 1ns / 1ps

module testbench;
   import lfsa_pkg::*;

   // one expected or observed reply
   typedef struct packed {
      status_type          status;
      logic [LVL_W-1:0]    level;
      logic [POS_W-1:0]    position;
   } reply_type;

   // Tracks which slots are held and by whom, and the replies still owed.
   class slot_ledger;
      bit                  occupied[SLOT_TOTAL];
      logic [TAG_BITS-1:0] holder[SLOT_TOTAL];
      logic [LVL_CFG_W-1:0] level_count;
      logic [SPL_CFG_W-1:0] slots_per_level;
      reply_type           expected_replies[$];
      int                  errors;

      function new();
         foreach (occupied[i]) occupied[i] = 1'b0;
         level_count     = LVL_CFG_W'(MAX_LEVELS);
         slots_per_level = SPL_CFG_W'(MAX_SLOTS_PER_LEVEL);
         errors          = 0;
      endfunction

      function void write_reg(reg_type r, logic [CSR_DATA_W-1:0] value);
         if (r == REG_LEVEL_COUNT) level_count = value[LVL_CFG_W-1:0];
         else slots_per_level = value[SPL_CFG_W-1:0];
      endfunction

      // first held slot with this tag over the whole array, in or out of use
      function int find_holder(logic [TAG_BITS-1:0] tag);
         for (int i = 0; i < SLOT_TOTAL; i++)
            if (occupied[i] && holder[i] == tag) return i;
         return -1;
      endfunction

      // Compute the reply to an accepted request and update the slot state.
      function void note_request(op_type op, logic [TAG_BITS-1:0] tag);
         int        lv_use;
         int        sp_use;
         int        hit;
         int        spot;
         int        where;
         reply_type r;
         lv_use = (int'(level_count) > MAX_LEVELS) ? MAX_LEVELS : int'(level_count);
         sp_use = (int'(slots_per_level) > MAX_SLOTS_PER_LEVEL) ?
                  MAX_SLOTS_PER_LEVEL : int'(slots_per_level);
         hit   = find_holder(tag);
         spot  = -1;
         where = -1;
         r.status = STATUS_OK;
         if (op == OP_ALLOC) begin
            for (int l = 0; l < lv_use && spot < 0; l++)
               for (int s = 0; s < sp_use && spot < 0; s++)
                  if (!occupied[l * MAX_SLOTS_PER_LEVEL + s]) spot = l * MAX_SLOTS_PER_LEVEL + s;
            // a full area wins over a duplicate tag
            if (spot < 0) r.status = STATUS_NO_FREE;
            else if (hit >= 0) r.status = STATUS_DUPLICATE;
            else begin
               occupied[spot] = 1'b1;
               holder[spot]   = tag;
               where          = spot;
            end
         end else if (hit < 0) begin
            r.status = STATUS_NOT_FOUND;
         end else begin
            occupied[hit] = 1'b0;
            where         = hit;
         end
         r.level    = (where < 0) ? '0 : LVL_W'(where / MAX_SLOTS_PER_LEVEL);
         r.position = (where < 0) ? '0 : POS_W'(where % MAX_SLOTS_PER_LEVEL);
         expected_replies = {expected_replies, r};
      endfunction

      // Compare an accepted reply against the oldest one owed.
      function void check_reply(reply_type got);
         reply_type want;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply: status %0d level %0d position %0d",
                     $time, got.status, got.level, got.position);
            errors++;
            return;
         end
         want = expected_replies.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.level !== want.level) begin
            $display("%0t: level_index mismatch: expected %0d, got %0d",
                     $time, want.level, got.level);
            errors++;
         end
         if (got.position !== want.position) begin
            $display("%0t: position_index mismatch: expected %0d, got %0d",
                     $time, want.position, got.position);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lfsa_req_if req_chan ();
   lfsa_rsp_if rsp_chan ();

   lowest_free_slot_allocator_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   slot_ledger          ledger = new();
   bit                  idle_on = 1'b1;
   bit                  long_hold = 1'b0;
   int                  random_sent = 0;
   logic [TAG_BITS-1:0] tag_pool[320];

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #36_000_000;
      $display("lowest_free_slot_allocator_top test failed");
      $finish;
   end

   // Offer one request, after a random gap when idle_on is set, and hold it until accepted.
   task automatic send_request(op_type op, logic [TAG_BITS-1:0] tag);
      int gap;
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= op;
      req_chan.owner_tag <= tag;
      do @(posedge clock); while (!req_chan.ready);
      ledger.note_request(op, tag);
   endtask

   // Drop valid and wait until every owed reply has come back.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (ledger.expected_replies.size() != 0);
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic write_csr(reg_type r, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(r));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      ledger.write_reg(r, value);
   endtask

   // Set the area in use once the block is idle; upper data bits are random.
   task automatic configure(int lv, int spl);
      logic [CSR_DATA_W-1:0] v;
      wait_idle();
      v = $urandom;
      v[LVL_CFG_W-1:0] = LVL_CFG_W'(lv);
      write_csr(REG_LEVEL_COUNT, v);
      v = $urandom;
      v[SPL_CFG_W-1:0] = SPL_CFG_W'(spl);
      write_csr(REG_SLOTS_PER_LEVEL, v);
   endtask

   // A run of random requests drawn mostly from the first pool_n tags.
   task automatic run_phase(int lv, int spl, int pool_n, int alloc_pct, int n, bit idle);
      op_type              op;
      logic [TAG_BITS-1:0] tag;
      configure(lv, spl);
      idle_on = idle;
      for (int i = 0; i < n; i++) begin
         op  = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
         tag = ($urandom_range(0, 99) < 8) ? $urandom : tag_pool[$urandom_range(0, pool_n - 1)];
         send_request(op, tag);
         random_sent++;
      end
   endtask

   // Take replies with random stalls when idle_on is set, once a long hold-off, and check them.
   initial begin
      int        stall;
      reply_type got;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold) begin
            stall     = 2000;
            long_hold = 1'b0;
         end else begin
            stall = idle_on ? $urandom_range(0, 9) : 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.status   = status_type'(rsp_chan.status);
         got.level    = rsp_chan.level_index;
         got.position = rsp_chan.position_index;
         ledger.check_reply(got);
      end
   end

   // Stimulus: reset, directed requests, then random phases.
   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.req_type  <= OP_ALLOC;
      req_chan.owner_tag <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // extreme tags, duplicate, missing tag, double release
      send_request(OP_ALLOC, 32'h0000_0000);
      send_request(OP_ALLOC, 32'hFFFF_FFFF);
      send_request(OP_ALLOC, 32'h0000_0000);
      send_request(OP_FREE,  32'h5A5A_5A5A);
      send_request(OP_FREE,  32'h0000_0000);
      send_request(OP_FREE,  32'h0000_0000);
      send_request(OP_ALLOC, 32'hA5A5_A5A5);
      // tiny area: full, full while duplicate, then duplicate alone
      configure(1, 2);
      send_request(OP_ALLOC, 32'h0000_0001);
      send_request(OP_ALLOC, 32'hFFFF_FFFF);
      send_request(OP_FREE,  32'hFFFF_FFFF);
      send_request(OP_ALLOC, 32'hA5A5_A5A5);
      send_request(OP_ALLOC, 32'h0000_0001);
      // zero levels, zero positions
      configure(0, 32);
      send_request(OP_ALLOC, 32'h0000_0002);
      configure(8, 0);
      send_request(OP_ALLOC, 32'h0000_0002);
      // values above the maximum saturate
      configure(15, 63);
      send_request(OP_ALLOC, 32'h0000_0002);
      send_request(OP_FREE,  32'h0000_0001);
      // shrunk area: slots outside it are still found and released
      configure(1, 1);
      send_request(OP_FREE,  32'h0000_0002);
      send_request(OP_ALLOC, 32'h0000_0003);
      send_request(OP_FREE,  32'hA5A5_A5A5);
      send_request(OP_ALLOC, 32'h0000_0003);
      send_request(OP_FREE,  32'h0000_0003);

      // fill the whole array under a long receiver hold-off, then shrink and drain
      configure(8, 32);
      long_hold = 1'b1;
      run_phase(8, 32, 320, 85, 330, 1'b1);
      run_phase(2, 3, 320, 40, 120, 1'b0);
      run_phase(8, 32, 320, 15, 380, 1'b1);
      run_phase(1, 1, 6, 50, 60, 1'b1);
      run_phase(0, 7, 16, 60, 30, 1'b0);
      run_phase(5, 0, 16, 60, 30, 1'b1);
      run_phase(15, 63, 40, 60, 60, 1'b1);
      while (random_sent < 1500) begin
         if ($urandom_range(0, 1))
            run_phase($urandom_range(1, 8), $urandom_range(1, 32), $urandom_range(4, 64),
                      $urandom_range(30, 80), 80, $urandom_range(0, 3) != 0);
         else
            run_phase($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(4, 64),
                      $urandom_range(30, 80), 80, $urandom_range(0, 3) != 0);
      end

      // drain and let any stray reply show up
      wait_idle();
      repeat (300) @(posedge clock);
      if (ledger.errors == 0 && ledger.expected_replies.size() == 0)
         $display("lowest_free_slot_allocator_top test passed");
      else
         $display("lowest_free_slot_allocator_top test failed");
      $finish;
   end

endmodule

// ----- lowest_free_slot_allocator_top.f -----
design/lfsa_pkg.sv
design/lfsa_req_if.sv
design/lfsa_rsp_if.sv
design/lfsa_cell.sv
design/lfsa_csr.sv
design/lowest_free_slot_allocator_top.sv
tb/testbench.sv
